FILE: hdl/tbdlp_pkg.sv
// Shared types and constants for the two-button debounce and long-press block.
package tbdlp_pkg;

    localparam int COUNT_W   = 4;
    localparam int LONG_W    = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 4'd4;
    localparam logic [LONG_W-1:0]  LONG_RESET     = 16'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_SAMPLES = 1'b0,
        REG_LONG_PRESS_MS    = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_A_SHORT = 2'd1,
        EV_B_SHORT = 2'd2,
        EV_B_LONG  = 2'd3
    } event_code_t;

    // Level changes confirmed by one debouncer in one scan.
    typedef struct packed {
        logic pressed;
        logic released;
    } deb_evt_t;

    // Events decided for button B in one scan.
    typedef struct packed {
        logic long_fire;
        logic short_fire;
    } lp_evt_t;

endpackage

FILE: hdl/tbdlp_if.sv
// Handshake interfaces for the scan input channel and the event output channel.
interface tbdlp_scan_if;
    logic        valid;
    logic        ready;
    logic        button_a_raw;
    logic        button_b_raw;
    logic [31:0] now_ms;

    modport source (output valid, button_a_raw, button_b_raw, now_ms, input ready);
    modport sink   (input valid, button_a_raw, button_b_raw, now_ms, output ready);
endinterface

interface tbdlp_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;

    modport source (output valid, event_code, input ready);
    modport sink   (input valid, event_code, output ready);
endinterface

FILE: hdl/tbdlp_debounce.sv
// Counter debouncer for one button: holds the stable level and the run counter.
module tbdlp_debounce (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           raw,
    input  logic [tbdlp_pkg::COUNT_W-1:0]  samples,
    output logic                           stable_new,
    output tbdlp_pkg::deb_evt_t            evt
);
    import tbdlp_pkg::*;

    logic               stable_reg;
    logic               stable_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               differ;
    logic               adopt;

    always_comb
    begin
        differ      = (raw != stable_reg);
        count_inc   = (count_reg < samples) ? count_reg + COUNT_W'(1) : count_reg;
        adopt       = differ && (count_inc >= samples);
        stable_next = adopt ? raw : stable_reg;
        count_next  = (!differ || adopt) ? '0 : count_inc;
        evt.pressed  = adopt && raw;
        evt.released = adopt && !raw;
        stable_new  = stable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (en)
        begin
            stable_reg <= stable_next;
            count_reg  <= count_next;
        end
    end

    // A confirmed change always leaves the counter cleared.
    a_clear_on_adopt: assert property (@(posedge clk) disable iff (!rst_n)
        en && (evt.pressed || evt.released) |=> count_reg == '0)
        else $error("debounce counter not cleared after a confirmed change");

endmodule

FILE: hdl/tbdlp_long_press.sv
// Long-press timing for button B: press timestamp, fired flag and B event decision.
module tbdlp_long_press (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          b_stable,
    input  tbdlp_pkg::deb_evt_t           b_evt,
    input  logic [tbdlp_pkg::TIME_W-1:0]  now_ms,
    input  logic [tbdlp_pkg::LONG_W-1:0]  long_ms,
    output tbdlp_pkg::lp_evt_t            lp_evt
);
    import tbdlp_pkg::*;

    logic [TIME_W-1:0] press_time_reg;
    logic [TIME_W-1:0] press_time_next;
    logic              fired_reg;
    logic              fired_next;
    logic              fired_eff;
    logic [TIME_W-1:0] elapsed;

    always_comb
    begin
        press_time_next  = b_evt.pressed ? now_ms : press_time_reg;
        fired_eff        = b_evt.pressed ? 1'b0 : fired_reg;
        elapsed          = now_ms - press_time_next;
        lp_evt.long_fire = b_stable && !fired_eff
                           && (elapsed >= {{(TIME_W-LONG_W){1'b0}}, long_ms});
        lp_evt.short_fire = b_evt.released && !fired_eff;
        fired_next       = fired_eff || lp_evt.long_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_time_reg <= '0;
            fired_reg      <= 1'b0;
        end
        else if (en)
        begin
            press_time_reg <= press_time_next;
            fired_reg      <= fired_next;
        end
    end

    // Once the long event has fired it cannot fire again until a new press.
    a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
        en && lp_evt.long_fire ##1 en && !b_evt.pressed |-> !lp_evt.long_fire)
        else $error("long event fired twice for one press");

endmodule

FILE: hdl/two_button_debounce_long_press.sv
// Top level of the two-button debounce and long-press block.
//
//  Channel   Direction  Transfer on            Payload
//  scan      in         valid & ready          button_a_raw, button_b_raw, now_ms
//  evt       out        valid & ready          event_code
//  cfg       in         cfg_we (no handshake)  cfg_index, cfg_data
//
// Each accepted scan is captured in an input register, processed by the two
// debouncers and the long-press logic, and its single event lands in the
// result register, from which it is offered on evt; one scan is taken per
// clock while evt is drained.
// The result register parts the two sides: a new scan is accepted while a
// finished event still waits, and only when both registers are full and evt is
// stalled does scan.ready fall.
// Reset (rst_n, asynchronous, active low) empties both registers, releases both
// buttons, clears the counters and loads debounce_samples = 4, long_press_ms = 600.
module two_button_debounce_long_press (
    input  logic                             clk,
    input  logic                             rst_n,
    tbdlp_scan_if.sink                       scan,
    tbdlp_event_if.source                    evt,
    input  logic                             cfg_we,
    input  tbdlp_pkg::cfg_idx_t              cfg_index,
    input  logic [tbdlp_pkg::CFG_W-1:0]      cfg_data
);
    import tbdlp_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0] debounce_samples_reg;
    logic [LONG_W-1:0]  long_press_ms_reg;

    // Input register: holds one scan until the processing step takes it.
    logic              s1_valid_reg;
    logic              a_raw_reg;
    logic              b_raw_reg;
    logic [TIME_W-1:0] now_reg;

    // Result register.
    logic        out_valid_reg;
    event_code_t out_code_reg;
    event_code_t code_next;

    logic        out_free;
    logic        s1_adv;
    logic        scan_take;
    logic        a_stable_new;
    logic        b_stable_new;
    deb_evt_t    a_evt;
    deb_evt_t    b_evt;
    lp_evt_t     lp_evt;

    // The processing step runs when the input register holds a scan and the
    // result register is empty or is being emptied in this cycle.
    assign out_free   = !out_valid_reg || evt.ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign scan.ready = !s1_valid_reg || out_free;
    assign scan_take  = scan.valid && scan.ready;

    assign evt.valid      = out_valid_reg;
    assign evt.event_code = out_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_samples_reg <= DEBOUNCE_RESET;
            long_press_ms_reg    <= LONG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_SAMPLES: debounce_samples_reg <= cfg_data[COUNT_W-1:0];
                REG_LONG_PRESS_MS:    long_press_ms_reg    <= cfg_data[LONG_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (scan.ready)
        begin
            s1_valid_reg <= scan.valid;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            a_raw_reg <= scan.button_a_raw;
            b_raw_reg <= scan.button_b_raw;
            now_reg   <= scan.now_ms;
        end
    end

    tbdlp_debounce u_deb_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (s1_adv),
        .raw        (a_raw_reg),
        .samples    (debounce_samples_reg),
        .stable_new (a_stable_new),
        .evt        (a_evt)
    );

    tbdlp_debounce u_deb_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (s1_adv),
        .raw        (b_raw_reg),
        .samples    (debounce_samples_reg),
        .stable_new (b_stable_new),
        .evt        (b_evt)
    );

    tbdlp_long_press u_long (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (s1_adv),
        .b_stable (b_stable_new),
        .b_evt    (b_evt),
        .now_ms   (now_reg),
        .long_ms  (long_press_ms_reg),
        .lp_evt   (lp_evt)
    );

    // One event per scan, highest priority first: B long, B short, A short.
    // A short counts on a confirmed release of A; lower events in the same
    // scan are dropped.
    always_comb
    begin
        if (lp_evt.long_fire)
        begin
            code_next = EV_B_LONG;
        end
        else if (lp_evt.short_fire)
        begin
            code_next = EV_B_SHORT;
        end
        else if (a_evt.released)
        begin
            code_next = EV_A_SHORT;
        end
        else
        begin
            code_next = EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_code_reg <= code_next;
        end
    end

    // A processed scan always leaves an event in the result register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("processed scan produced no result");

    // The scan side is only held off when both registers are occupied.
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !scan.ready |-> s1_valid_reg && out_valid_reg && !evt.ready)
        else $error("scan stalled with room in the pipeline");

    // A waiting scan is processed no later than the cycle the result is taken.
    a_drain_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && evt.ready |-> s1_adv)
        else $error("input register not processed although result was taken");

    // A long event never reaches the output without button B held down.
    a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && lp_evt.long_fire |-> b_stable_new)
        else $error("long event with button B released");

    // A confirmed press of A leaves A's stable level at pressed.
    a_press_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && a_evt.pressed |-> a_stable_new)
        else $error("press of A confirmed without adopting the pressed level");

endmodule

FILE: tb/sv/tb_two_button_debounce_long_press.sv
// Self-checking testbench for the two-button debounce and long-press block.
`timescale 1ns / 1ps

module tb_two_button_debounce_long_press;

    import tbdlp_pkg::*;

    // Cycles allowed after the last event for the two pipeline registers to empty.
    localparam int SETTLE_CYCLES = 6;
    // Upper bound on the cycles spent waiting for outstanding events to drain.
    localparam int DRAIN_LIMIT   = 20000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    cfg_idx_t            cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    tbdlp_scan_if  scan_ch ();
    tbdlp_event_if evt_ch ();

    two_button_debounce_long_press i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan      (scan_ch),
        .evt       (evt_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Events predicted for accepted scans, oldest first.
    event_code_t expected_events[$];
    int          error_count = 0;

    // When set, neither the scan source nor the event sink idles.
    bit          quiet = 1'b0;

    // The predictor's copy of the configuration, updated as each register is written.
    logic [COUNT_W-1:0] cfg_samples = DEBOUNCE_RESET;
    logic [LONG_W-1:0]  cfg_long_ms = LONG_RESET;

    // The predictor's copy of the debouncer and long-press state.
    logic               a_level       = 1'b0;
    logic [COUNT_W-1:0] a_run         = '0;
    logic               b_level       = 1'b0;
    logic [COUNT_W-1:0] b_run         = '0;
    logic [TIME_W-1:0]  b_press_stamp = '0;
    logic               b_long_done   = 1'b0;

    // State of the random scan generator: the level each button is heading for,
    // how many more scans it is held there, and the running millisecond clock.
    logic               a_target  = 1'b0;
    int                 a_hold    = 0;
    logic               b_target  = 1'b0;
    int                 b_hold    = 0;
    logic [TIME_W-1:0]  clock_ms  = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hard ceiling on the run, far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10)
            return 0;
        else if (r < 14)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // One counter debouncer. A sample that matches the stable level clears the
    // counter; a differing one counts up, and the new level is adopted once the
    // count reaches the configured number of samples. With zero samples the
    // new level is therefore adopted on the very first differing scan.
    function automatic deb_evt_t debounce_step(input logic raw,
                                               inout logic level,
                                               inout logic [COUNT_W-1:0] run);
        deb_evt_t ev;
        ev = '0;
        if (raw == level)
        begin
            run = '0;
        end
        else
        begin
            if (run < cfg_samples)
                run = run + 1'b1;
            if (run >= cfg_samples)
            begin
                level       = raw;
                run         = '0;
                ev.pressed  = raw;
                ev.released = ~raw;
            end
        end
        return ev;
    endfunction

    // Works out the single event that one scan causes and advances the state.
    function automatic event_code_t predict_event(input logic a_raw, input logic b_raw,
                                                  input logic [TIME_W-1:0] now);
        deb_evt_t          ea;
        deb_evt_t          eb;
        logic [TIME_W-1:0] held_ms;
        ea = debounce_step(a_raw, a_level, a_run);
        eb = debounce_step(b_raw, b_level, b_run);
        if (eb.pressed)
        begin
            b_press_stamp = now;
            b_long_done   = 1'b0;
        end
        // The held time wraps modulo 2^32, so a press straddling the wrap of
        // the timestamp still measures correctly.
        held_ms = now - b_press_stamp;
        if (b_level && !b_long_done && held_ms >= {16'd0, cfg_long_ms})
        begin
            b_long_done = 1'b1;
            return EV_B_LONG;
        end
        // A release after the long event has fired yields nothing, and any
        // A release in the same scan as a B event is lost.
        if (eb.released && !b_long_done)
            return EV_B_SHORT;
        if (ea.released)
            return EV_A_SHORT;
        return EV_NONE;
    endfunction

    // Offers one scan, waits for its transfer and records the predicted event.
    // Ready is looked at on the falling edge, where it is settled, so the
    // transfer is the rising edge that follows.
    task automatic send_scan(input logic a_raw, input logic b_raw,
                             input logic [TIME_W-1:0] now);
        int   gap;
        logic taken;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_ch.valid        <= 1'b1;
        scan_ch.button_a_raw <= a_raw;
        scan_ch.button_b_raw <= b_raw;
        scan_ch.now_ms       <= now;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = scan_ch.ready;
            @(posedge clk);
        end
        expected_events.push_back(predict_event(a_raw, b_raw, now));
    endtask

    // Stops offering scans and waits until every predicted event has been
    // taken, then lets the pipeline settle.
    task automatic wait_drained();
        int guard;
        scan_ch.valid <= 1'b0;
        guard = 0;
        while (expected_events.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers while the block is idle. The debounce register is
    // only four bits wide, so the unused upper data bits carry random junk.
    task automatic set_config(input logic [COUNT_W-1:0] samples,
                              input logic [LONG_W-1:0] long_ms);
        logic [CFG_W-COUNT_W-1:0] junk;
        junk = (CFG_W-COUNT_W)'($urandom());
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE_SAMPLES;
        cfg_data  <= {junk, samples};
        @(posedge clk);
        cfg_samples = samples;
        cfg_index <= REG_LONG_PRESS_MS;
        cfg_data  <= long_ms;
        @(posedge clk);
        cfg_long_ms = long_ms;
        cfg_we <= 1'b0;
    endtask

    // Sink side: drives ready with random stalls and checks every transfer
    // against the oldest predicted event.
    initial
    begin : event_checker
        int stall_left;
        stall_left = 0;
        evt_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (quiet || stall_left == 0)
            begin
                evt_ch.ready <= 1'b1;
                if (!quiet)
                    stall_left = pick_gap();
            end
            else
            begin
                evt_ch.ready <= 1'b0;
                stall_left--;
            end
            @(negedge clk);
            if (rst_n && evt_ch.valid && evt_ch.ready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("event %0d with none expected",
                                              evt_ch.event_code));
                else if (evt_ch.event_code !== expected_events[0])
                begin
                    report_mismatch($sformatf("event_code %0d, expected %0d",
                                              evt_ch.event_code, expected_events[0]));
                    void'(expected_events.pop_front());
                end
                else
                    void'(expected_events.pop_front());
            end
        end
    end

    // With the reset settings (four samples, 600 ms): a bounce part way through
    // a press restarts the count, both buttons are confirmed together, the long
    // event fires exactly at the threshold and not one millisecond before, and
    // the release of B after its long event yields nothing while A's release
    // still yields its short event.
    task automatic test_reset_values();
        send_scan(1'b0, 1'b1, 32'd100);
        send_scan(1'b0, 1'b1, 32'd101);
        send_scan(1'b0, 1'b1, 32'd102);
        send_scan(1'b0, 1'b0, 32'd103);
        send_scan(1'b1, 1'b1, 32'd104);
        send_scan(1'b1, 1'b1, 32'd105);
        send_scan(1'b1, 1'b1, 32'd106);
        send_scan(1'b1, 1'b1, 32'd107);
        send_scan(1'b0, 1'b1, 32'd706);
        send_scan(1'b0, 1'b1, 32'd707);
        send_scan(1'b0, 1'b0, 32'd708);
        send_scan(1'b0, 1'b0, 32'd709);
        send_scan(1'b0, 1'b0, 32'd710);
        send_scan(1'b0, 1'b0, 32'd711);
    endtask

    // Zero samples and zero threshold: every level change is adopted at once
    // and the long event fires in the very scan that confirms the press. It
    // also swallows an A release in the same scan. A B short with a zero
    // threshold is impossible, so the threshold is then raised to its maximum
    // to show a B short dropping a simultaneous A short.
    task automatic test_zero_settings();
        set_config(4'd0, 16'd0);
        send_scan(1'b1, 1'b0, 32'h0000_0000);
        send_scan(1'b0, 1'b1, 32'h0000_0001);
        send_scan(1'b0, 1'b0, 32'h0000_0002);
        set_config(4'd0, 16'hFFFF);
        send_scan(1'b1, 1'b1, 32'h0000_0003);
        send_scan(1'b0, 1'b0, 32'h0000_0004);
    endtask

    // The largest threshold across the wrap of the timestamp: one millisecond
    // short of the threshold gives nothing, the threshold itself fires, and a
    // later scan with the top timestamp does not fire a second time.
    task automatic test_wrapping_long_press();
        set_config(4'd2, 16'hFFFF);
        send_scan(1'b0, 1'b1, 32'hFFFF_F000);
        send_scan(1'b0, 1'b1, 32'hFFFF_F001);
        send_scan(1'b0, 1'b1, 32'h0000_EFFF);
        send_scan(1'b0, 1'b1, 32'h0000_F000);
        send_scan(1'b0, 1'b1, 32'hFFFF_FFFF);
        send_scan(1'b0, 1'b0, 32'h0001_0000);
        send_scan(1'b0, 1'b0, 32'h0001_0001);
    endtask

    // Realistic scans: each button heads for a level and holds it for a random
    // number of scans, with the odd single-sample bounce, while the clock moves
    // on in steps scaled to the threshold so that some presses go long and
    // others are short. About one scan in ten is pure noise.
    task automatic run_random_scans(input int n_items, input bit drain_midway);
        int          step_max;
        logic        a_bit;
        logic        b_bit;
        step_max = int'(cfg_long_ms) / 8 + 2;
        for (int i = 0; i < n_items; i++)
        begin
            // Hold the source off at least once until every event is back.
            if (drain_midway && i == n_items / 2)
                wait_drained();
            if ($urandom_range(0, 9) == 0)
            begin
                send_scan(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
            end
            else
            begin
                if (a_hold == 0)
                begin
                    a_target = ~a_target;
                    a_hold   = $urandom_range(0, 2 * int'(cfg_samples) + 4);
                end
                else
                    a_hold--;
                if (b_hold == 0)
                begin
                    b_target = ~b_target;
                    b_hold   = $urandom_range(0, 3 * int'(cfg_samples) + 8);
                end
                else
                    b_hold--;
                a_bit = a_target ^ ($urandom_range(0, 7) == 0);
                b_bit = b_target ^ ($urandom_range(0, 7) == 0);
                clock_ms = clock_ms + $urandom_range(0, step_max);
                send_scan(a_bit, b_bit, clock_ms);
            end
        end
    endtask

    // Several settings in turn, the extremes among them, one phase without any
    // idling on either side and one that restores the reset values.
    task automatic test_random_scans();
        set_config(4'd1, 16'd20);
        run_random_scans(120, 1'b0);

        set_config(4'd15, 16'hFFFF);
        clock_ms = $urandom();
        run_random_scans(120, 1'b0);

        set_config(4'd0, 16'd0);
        run_random_scans(100, 1'b0);

        set_config(4'd3, 16'd1);
        quiet = 1'b1;
        run_random_scans(100, 1'b0);
        quiet = 1'b0;

        // Start just below the wrap so that presses straddle it.
        set_config(COUNT_W'($urandom_range(1, 15)), LONG_W'($urandom_range(0, 300)));
        clock_ms = 32'hFFFF_FF00;
        run_random_scans(120, 1'b1);

        set_config(COUNT_W'($urandom_range(1, 6)), LONG_W'($urandom()));
        run_random_scans(120, 1'b0);

        set_config(DEBOUNCE_RESET, LONG_RESET);
        run_random_scans(120, 1'b0);
    endtask

    initial
    begin
        // Every input is given a known value before the first clock edge.
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_DEBOUNCE_SAMPLES;
        cfg_data             <= '0;
        scan_ch.valid        <= 1'b0;
        scan_ch.button_a_raw <= 1'b0;
        scan_ch.button_b_raw <= 1'b0;
        scan_ch.now_ms       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_zero_settings();
        test_wrapping_long_press();
        test_random_scans();

        wait_drained();
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/tbdlp_pkg.sv
hdl/tbdlp_if.sv
hdl/tbdlp_debounce.sv
hdl/tbdlp_long_press.sv
hdl/two_button_debounce_long_press.sv
tb/sv/tb_two_button_debounce_long_press.sv
